/* sv/lru_block_buffer_cache_assert.svh */
// Assertion macros for the buffer cache checker.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef LRU_BLOCK_BUFFER_CACHE_ASSERT_SVH
`define LRU_BLOCK_BUFFER_CACHE_ASSERT_SVH

// same-cycle implication
`define LBBC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lbbc assertion failed");

// next-cycle implication
`define LBBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lbbc assertion failed");

`endif

/* sv/lbbc_pkg.sv */
// Shared types and codes of the LRU block buffer cache.
// No dependencies.
`default_nettype none

package lbbc_pkg;

    localparam int CMD_W    = 2;
    localparam int DEV_W    = 8;
    localparam int BLK_W    = 32;
    localparam int ENTRY_W  = 4;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 6;
    localparam int OP_W     = 3;

    localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WBACK   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_GRANTED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BUSY    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOFREE  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_ACK     = 2'd3;

    localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
    localparam logic [OP_W-1:0] OP_GRANT   = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD    = 3'd2;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd3;
    localparam logic [OP_W-1:0] OP_WBACK   = 3'd4;

    typedef struct packed {
        logic [DEV_W-1:0]   device;
        logic [BLK_W-1:0]   block_number;
        logic [ENTRY_W-1:0] entry;
    } t_key;

    typedef struct packed {
        logic             any_match;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic [IDX_W-1:0] free_rank;
        logic             free_valid;
        logic             victim_found;
        logic [IDX_W-1:0] victim_idx;
        logic [IDX_W-1:0] victim_rank;
        logic             sel_found;
        logic [IDX_W-1:0] sel_rank;
    } t_scan;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] rank_ref;
    } t_upd;

endpackage

`default_nettype wire

/* sv/lbbc_if.sv */
// Request and response channel interfaces.
// Depends on lbbc_pkg.
`default_nettype none

interface lbbc_req_if import lbbc_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [DEV_W-1:0]   device;
    logic [BLK_W-1:0]   block_number;
    logic [ENTRY_W-1:0] entry;

    modport source (output valid, cmd, device, block_number, entry, input ready);
    modport sink (input valid, cmd, device, block_number, entry, output ready);
endinterface

interface lbbc_rsp_if import lbbc_pkg::*; ;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0]  granted_entry;
    logic                need_read;

    modport source (output valid, status, granted_entry, need_read, input ready);
    modport sink (input valid, status, granted_entry, need_read, output ready);
endinterface

`default_nettype wire

/* sv/lru_block_buffer_cache.sv */
// Each request is scanned by a wave that moves one entry cell per cycle down the
// cell chain; the response is registered once the wave has left the last cell
// and the response register is free. A new request is taken only after the scan
// of the previous one has ended, and may be taken while that response waits.
// Reset: synchronous, active low; all entries invalid and free, zero tags,
// recency order by entry index with entry 0 most recent.
`default_nettype none

module lru_block_buffer_cache import lbbc_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    lbbc_req_if.sink   i_req,
    lbbc_rsp_if.source o_rsp
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic             r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CMD_W-1:0] r_cmd;
    t_key             r_key;

    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [IDX_W-1:0]    r_gidx, n_gidx;
    logic                r_nr, n_nr;

    t_scan w_chain [ENTRIES+1];
    t_scan w_last;
    t_upd  w_upd, w_upd_calc;
    logic  w_accept, w_done, w_fire;

    assign w_chain[0] = '0;
    assign w_last     = w_chain[ENTRIES];

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            lbbc_cell #(
                .ENTRIES (ENTRIES),
                .INDEX   (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_key   (r_key),
                .i_upd   (w_upd),
                .i_scan  (w_chain[g]),
                .o_scan  (w_chain[g+1])
            );
        end
    endgenerate

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_done      = (r_state == S_SCAN) && (r_cnt == CNT_W'(ENTRIES));
    assign w_fire      = w_done && (!r_out_valid || o_rsp.ready);

    always_comb begin
        w_upd_calc = '0;
        w_upd_calc.op = OP_NONE;
        n_status = STAT_ACK;
        n_gidx   = '0;
        n_nr     = 1'b0;
        case (r_cmd)
            CMD_ACQUIRE: begin
                if (w_last.free_found) begin
                    w_upd_calc.op  = OP_GRANT;
                    w_upd_calc.idx = w_last.free_idx;
                    n_status       = STAT_GRANTED;
                    n_gidx         = w_last.free_idx;
                    n_nr           = !w_last.free_valid;
                end else if (w_last.any_match) begin
                    n_status = STAT_BUSY;
                end else if (w_last.victim_found) begin
                    w_upd_calc.op  = OP_LOAD;
                    w_upd_calc.idx = w_last.victim_idx;
                    n_status       = STAT_GRANTED;
                    n_gidx         = w_last.victim_idx;
                    n_nr           = 1'b1;
                end else begin
                    n_status = STAT_NOFREE;
                end
            end
            CMD_RELEASE: begin
                if (w_last.sel_found) begin
                    w_upd_calc.op       = OP_RELEASE;
                    w_upd_calc.idx      = IDX_W'(r_key.entry);
                    w_upd_calc.rank_ref = w_last.sel_rank;
                end
            end
            CMD_WBACK: begin
                w_upd_calc.op  = OP_WBACK;
                w_upd_calc.idx = IDX_W'(r_key.entry);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_upd = w_upd_calc;
        if (!w_fire) begin
            w_upd.op = OP_NONE;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                    n_cnt   = '0;
                end
            end
            S_SCAN: begin
                if (w_fire) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end else if (!w_done) begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd                <= i_req.cmd;
            r_key.device         <= i_req.device;
            r_key.block_number   <= i_req.block_number;
            r_key.entry          <= i_req.entry;
        end
        if (w_fire) begin
            r_status <= n_status;
            r_gidx   <= n_gidx;
            r_nr     <= n_nr;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.granted_entry = r_gidx[ENTRY_W-1:0];
    assign o_rsp.need_read     = r_nr;

endmodule

`default_nettype wire

/* sv/lbbc_cell.sv */
// One buffer entry: tag, valid, busy and recency rank, plus one scan stage.
// Depends on lbbc_pkg.
`default_nettype none

module lbbc_cell import lbbc_pkg::*; #(
    parameter int ENTRIES = 16,
    parameter int INDEX   = 0
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  t_key  i_key,
    input  t_upd  i_upd,
    input  t_scan i_scan,
    output t_scan o_scan
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] SELF = IDX_W'(INDEX);

    logic [DEV_W-1:0] r_dev, n_dev;
    logic [BLK_W-1:0] r_blk, n_blk;
    logic             r_valid, n_valid;
    logic             r_busy, n_busy;
    logic [IW-1:0]    r_rank, n_rank;
    t_scan            r_scan, n_scan;

    logic             w_match;
    logic [IDX_W-1:0] w_rank;
    logic             w_self;

    assign w_match = (r_dev == i_key.device) && (r_blk == i_key.block_number);
    assign w_rank  = IDX_W'(r_rank);
    assign w_self  = (i_upd.idx == SELF);

    always_comb begin
        n_scan = i_scan;
        if (w_match) begin
            n_scan.any_match = 1'b1;
            if (!r_busy && (!i_scan.free_found || w_rank < i_scan.free_rank)) begin
                n_scan.free_found = 1'b1;
                n_scan.free_idx   = SELF;
                n_scan.free_rank  = w_rank;
                n_scan.free_valid = r_valid;
            end
        end
        if (!r_busy && (!i_scan.victim_found || w_rank > i_scan.victim_rank)) begin
            n_scan.victim_found = 1'b1;
            n_scan.victim_idx   = SELF;
            n_scan.victim_rank  = w_rank;
        end
        if (IDX_W'(i_key.entry) == SELF) begin
            n_scan.sel_found = 1'b1;
            n_scan.sel_rank  = w_rank;
        end
    end

    always_comb begin
        n_dev   = r_dev;
        n_blk   = r_blk;
        n_valid = r_valid;
        n_busy  = r_busy;
        n_rank  = r_rank;
        case (i_upd.op)
            OP_GRANT: begin
                if (w_self) begin
                    n_busy  = 1'b1;
                    n_valid = 1'b1;
                end
            end
            OP_LOAD: begin
                if (w_self) begin
                    n_busy  = 1'b1;
                    n_valid = 1'b1;
                    n_dev   = i_key.device;
                    n_blk   = i_key.block_number;
                end
            end
            OP_RELEASE: begin
                if (w_self) begin
                    n_busy = 1'b0;
                    n_rank = '0;
                end else if (w_rank < i_upd.rank_ref) begin
                    n_rank = r_rank + 1'b1;
                end
            end
            OP_WBACK: begin
                if (w_self) begin
                    n_valid = 1'b1;
                    n_busy  = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev   <= '0;
            r_blk   <= '0;
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
            r_rank  <= IW'(INDEX);
        end else begin
            r_dev   <= n_dev;
            r_blk   <= n_blk;
            r_valid <= n_valid;
            r_busy  <= n_busy;
            r_rank  <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
    end

    assign o_scan = r_scan;

endmodule

`default_nettype wire

/* sv/lbbc_checker.sv */
// Port-level checks of the buffer cache, bound to the top level.
// Depends on lbbc_pkg and lru_block_buffer_cache_assert.svh.
`default_nettype none

`include "lru_block_buffer_cache_assert.svh"

module lbbc_checker import lbbc_pkg::*; (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_req_valid,
    input wire                i_req_ready,
    input wire                i_rsp_valid,
    input wire                i_rsp_ready,
    input wire [STATUS_W-1:0] i_rsp_status,
    input wire [ENTRY_W-1:0]  i_rsp_entry,
    input wire                i_rsp_need_read
)
;

    logic w_req_take;
    logic w_rsp_hold;
    logic w_not_granted;

    assign w_req_take    = i_req_valid && i_req_ready;
    assign w_rsp_hold    = i_rsp_valid && !i_rsp_ready;
    assign w_not_granted = i_rsp_valid && (i_rsp_status != STAT_GRANTED);

    `LBBC_ASSERT_NEXT(a_rsp_hold, w_rsp_hold, i_rsp_valid)
    `LBBC_ASSERT_NOW(a_quiet_fields, w_not_granted, (i_rsp_entry == '0) && !i_rsp_need_read)
    `LBBC_ASSERT_NEXT(a_busy_after_take, w_req_take, !i_req_ready)
    `LBBC_ASSERT_NOW(a_rsp_from_scan, $rose(i_rsp_valid), $past(!i_req_ready))

endmodule

bind lru_block_buffer_cache lbbc_checker u_lbbc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_status    (o_rsp.status),
    .i_rsp_entry     (o_rsp.granted_entry),
    .i_rsp_need_read (o_rsp.need_read)
);

`default_nettype wire

/* test/lru_block_buffer_cache_test.sv */
`timescale 1ns / 1ps
// Testbench for lru_block_buffer_cache: random and directed acquire, release, write-back
// and no-op requests, each response checked against a cycle-free cache predictor.
// Depends on lbbc_pkg, lbbc_if and the lru_block_buffer_cache RTL.

module lru_block_buffer_cache_test;
    import lbbc_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int QUIET_FROM  = 4000;
    localparam int QUIET_TO    = 9000;
    localparam int POOL_KEYS   = 12;
    localparam int DIRECTED    = 23;
    localparam int RANDOM_REQS = 1200;

    localparam logic [CMD_W-1:0] CMD_NOOP = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [DEV_W-1:0]   device;
        logic [BLK_W-1:0]   block_number;
        logic [ENTRY_W-1:0] entry;
    } t_cache_request;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ENTRY_W-1:0]  granted_entry;
        logic                need_read;
    } t_cache_answer;

    logic i_clk;
    logic i_rst_n;

    lbbc_req_if req_ch();
    lbbc_rsp_if rsp_ch();

    lru_block_buffer_cache #(.ENTRIES(ENTRIES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    logic [DEV_W-1:0] tag_dev [ENTRIES];
    logic [BLK_W-1:0] tag_blk [ENTRIES];
    bit               valid_bits [ENTRIES];
    bit               busy_bits [ENTRIES];
    int               rank_of [ENTRIES];

    logic [DEV_W-1:0] pool_dev [POOL_KEYS];
    logic [BLK_W-1:0] pool_blk [POOL_KEYS];

    t_cache_request pending_requests[$];
    t_cache_answer  answers_due[$];
    t_cache_request next_req;
    t_cache_request taken_req;
    t_cache_answer  due_answer;

    int errors = 0;
    int cycle_count = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int reads_seen = 0;
    bit req_fire = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic note_error(input string msg);
        errors++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic queue_request(input logic [CMD_W-1:0] c, input logic [DEV_W-1:0] d,
                                 input logic [BLK_W-1:0] b, input logic [ENTRY_W-1:0] e);
        pending_requests.push_back('{cmd: c, device: d, block_number: b, entry: e});
    endtask

    function automatic bit idle_now();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
            return 1'b0;
        return $urandom_range(99) < 31;
    endfunction

    function automatic t_cache_answer predict_access(input t_cache_request rq);
        t_cache_answer ans;
        bit any_match;
        bit free_found;
        bit victim_found;
        int free_idx;
        int free_rank;
        int victim_idx;
        int victim_rank;
        int r;
        ans = '{status: STAT_ACK, granted_entry: '0, need_read: 1'b0};
        any_match = 1'b0;
        free_found = 1'b0;
        victim_found = 1'b0;
        free_idx = 0;
        free_rank = 0;
        victim_idx = 0;
        victim_rank = 0;
        case (rq.cmd)
            CMD_ACQUIRE: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tag_dev[i] == rq.device && tag_blk[i] == rq.block_number) begin
                        any_match = 1'b1;
                        if (!busy_bits[i] && (!free_found || rank_of[i] < free_rank)) begin
                            free_found = 1'b1;
                            free_idx = i;
                            free_rank = rank_of[i];
                        end
                    end
                    if (!busy_bits[i] && (!victim_found || rank_of[i] > victim_rank)) begin
                        victim_found = 1'b1;
                        victim_idx = i;
                        victim_rank = rank_of[i];
                    end
                end
                if (free_found) begin
                    ans = '{status: STAT_GRANTED, granted_entry: ENTRY_W'(free_idx),
                            need_read: !valid_bits[free_idx]};
                    busy_bits[free_idx] = 1'b1;
                    valid_bits[free_idx] = 1'b1;
                end else if (any_match) begin
                    ans.status = STAT_BUSY;
                end else if (victim_found) begin
                    ans = '{status: STAT_GRANTED, granted_entry: ENTRY_W'(victim_idx),
                            need_read: 1'b1};
                    tag_dev[victim_idx] = rq.device;
                    tag_blk[victim_idx] = rq.block_number;
                    busy_bits[victim_idx] = 1'b1;
                    valid_bits[victim_idx] = 1'b1;
                end else begin
                    ans.status = STAT_NOFREE;
                end
            end
            CMD_RELEASE: begin
                if (rq.entry < ENTRIES) begin
                    busy_bits[rq.entry] = 1'b0;
                    r = rank_of[rq.entry];
                    for (int i = 0; i < ENTRIES; i++)
                        if (rank_of[i] < r)
                            rank_of[i]++;
                    rank_of[rq.entry] = 0;
                end
            end
            CMD_WBACK: begin
                if (rq.entry < ENTRIES) begin
                    valid_bits[rq.entry] = 1'b1;
                    busy_bits[rq.entry] = 1'b0;
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    // Advance the request channel and randomize response backpressure.
    always @(negedge i_clk) begin
        rsp_ch.ready <= i_rst_n && !idle_now();
        if (i_rst_n && (!req_ch.valid || req_fire)) begin
            if (pending_requests.size() != 0 && !idle_now()) begin
                next_req = pending_requests.pop_front();
                req_ch.cmd          <= next_req.cmd;
                req_ch.device       <= next_req.device;
                req_ch.block_number <= next_req.block_number;
                req_ch.entry        <= next_req.entry;
                req_ch.valid        <= 1'b1;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Check responses first, then predict the request taken at this edge.
    always @(posedge i_clk) begin
        req_fire <= i_rst_n && req_ch.valid && req_ch.ready;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            status_seen[rsp_ch.status]++;
            if (rsp_ch.status == STAT_GRANTED && rsp_ch.need_read)
                reads_seen++;
            if (answers_due.size() == 0) begin
                note_error($sformatf("unexpected response status=%0d entry=%0d need_read=%0b",
                                     rsp_ch.status, rsp_ch.granted_entry, rsp_ch.need_read));
            end else begin
                due_answer = answers_due.pop_front();
                if (rsp_ch.status !== due_answer.status)
                    note_error($sformatf("status %0d, expected %0d",
                                         rsp_ch.status, due_answer.status));
                if (rsp_ch.granted_entry !== due_answer.granted_entry)
                    note_error($sformatf("granted_entry %0d, expected %0d",
                                         rsp_ch.granted_entry, due_answer.granted_entry));
                if (rsp_ch.need_read !== due_answer.need_read)
                    note_error($sformatf("need_read %0b, expected %0b",
                                         rsp_ch.need_read, due_answer.need_read));
            end
        end
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            taken_req = '{cmd: req_ch.cmd, device: req_ch.device,
                          block_number: req_ch.block_number, entry: req_ch.entry};
            answers_due.push_back(predict_access(taken_req));
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, answers_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_cache_request rq;
        bit filling;
        int pick;
        int slot;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_ACQUIRE;
        req_ch.device = '0;
        req_ch.block_number = '0;
        req_ch.entry = '0;
        rsp_ch.ready = 1'b0;
        filling = 1'b0;

        for (int i = 0; i < ENTRIES; i++) begin
            tag_dev[i] = '0;
            tag_blk[i] = '0;
            valid_bits[i] = 1'b0;
            busy_bits[i] = 1'b0;
            rank_of[i] = i;
        end
        pool_dev[0] = '0;
        pool_blk[0] = '0;
        pool_dev[1] = '1;
        pool_blk[1] = '1;
        for (int i = 2; i < POOL_KEYS; i++) begin
            pool_dev[i] = DEV_W'($urandom);
            pool_blk[i] = BLK_W'($urandom);
        end

        // Zero tags match every entry after reset: grant all, then hit busy and no free.
        repeat (ENTRIES) queue_request(CMD_ACQUIRE, '0, '0, '0);
        queue_request(CMD_ACQUIRE, '0, '0, '1);
        queue_request(CMD_ACQUIRE, '1, '1, '0);
        queue_request(CMD_RELEASE, '0, '0, '1);
        queue_request(CMD_WBACK, '1, '1, '0);
        queue_request(CMD_NOOP, '1, '1, '1);
        queue_request(CMD_ACQUIRE, '0, '0, '0);
        queue_request(CMD_ACQUIRE, '1, '1, '1);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 40 == 0)
                filling = 1'($urandom_range(1));
            pick = int'($urandom_range(99));
            rq.device = DEV_W'($urandom);
            rq.block_number = BLK_W'($urandom);
            rq.entry = ENTRY_W'($urandom);
            if (pick < (filling ? 70 : 40)) begin
                rq.cmd = CMD_ACQUIRE;
                slot = int'($urandom_range(POOL_KEYS - 1));
                if ($urandom_range(99) < 85) begin
                    rq.device = pool_dev[slot];
                    rq.block_number = pool_blk[slot];
                end else if ($urandom_range(1) != 0) begin
                    pool_dev[slot] = rq.device;
                    pool_blk[slot] = rq.block_number;
                end
            end else if (pick < (filling ? 85 : 75)) begin
                rq.cmd = CMD_RELEASE;
            end else if (pick < 95) begin
                rq.cmd = CMD_WBACK;
            end else begin
                rq.cmd = CMD_NOOP;
            end
            pending_requests.push_back(rq);
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_requests.size() != 0 || req_ch.valid)
            @(posedge i_clk);
        while (answers_due.size() != 0)
            @(posedge i_clk);
        repeat (4 * ENTRIES) @(posedge i_clk);

        $display("%0d directed and %0d random requests over %0d cycles",
                 DIRECTED, RANDOM_REQS, cycle_count);
        $display("responses: %0d granted (%0d needing a read), %0d busy, %0d no free, %0d acked",
                 status_seen[STAT_GRANTED], reads_seen, status_seen[STAT_BUSY],
                 status_seen[STAT_NOFREE], status_seen[STAT_ACK]);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/lbbc_pkg.sv
sv/lbbc_if.sv
sv/lbbc_cell.sv
sv/lru_block_buffer_cache.sv
sv/lbbc_checker.sv
test/lru_block_buffer_cache_test.sv
